### hdl/udw_pkg.sv
// udw_pkg: shared types, byte constants and the column width lookup for the
// UTF-8 display width block. No dependencies.
`default_nettype none

package udw_pkg;

  // CSI escape tracking, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_PARAM = 4'b0100,
    PH_INTER = 4'b1000
  } esc_phase_t;

  localparam int unsigned OUT_W = 20;

  localparam logic [7:0]  BYTE_ESC     = 8'h1B;
  localparam logic [7:0]  BYTE_BRACKET = 8'h5B;
  localparam logic [20:0] CP_ESC       = 21'h0001B;
  localparam logic [20:0] CP_ZWJ       = 21'h0200D;

  // Columns taken by one codepoint: 0, 1 or 2
  function automatic logic [1:0] col_width(input logic [20:0] cp);
    logic [1:0] w;
    begin
      if (cp inside {[21'h00000:21'h0001F], [21'h0007F:21'h0009F],
                     [21'h00300:21'h0036F], [21'h01AB0:21'h01AFF],
                     [21'h01DC0:21'h01DFF], CP_ZWJ,
                     [21'h020D0:21'h020FF], [21'h0FE0E:21'h0FE0F],
                     [21'h0FE20:21'h0FE2F], [21'h1F3FB:21'h1F3FF]}) begin
        w = 2'd0;
      end else if (cp inside {[21'h01100:21'h0115F], [21'h0231A:21'h0231B],
                              [21'h02329:21'h0232A], [21'h023E9:21'h023F3],
                              [21'h023F8:21'h023FA], [21'h025AA:21'h025AB],
                              [21'h025B6:21'h025C0], [21'h025FB:21'h025FE],
                              [21'h02600:21'h027BF], [21'h02934:21'h02935],
                              [21'h02B05:21'h02B07], [21'h02B1B:21'h02B1C],
                              21'h02B50, 21'h02B55,
                              [21'h02E80:21'h0303E], [21'h03040:21'h0A4CF],
                              [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                              [21'h0FE10:21'h0FE1F], [21'h0FE30:21'h0FE6F],
                              [21'h0FF00:21'h0FF60], [21'h0FFE0:21'h0FFE6],
                              [21'h1F1E6:21'h1F1FF], [21'h1F300:21'h1F64F],
                              [21'h1F680:21'h1F6FF], [21'h1F900:21'h1FAFF],
                              [21'h20000:21'h2FFFF]}) begin
        w = 2'd2;
      end else begin
        w = 2'd1;
      end
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/utf8_display_width_top.sv
// A byte is taken into the byte register and decoded from there; the result for a
// last byte is then written to the result register when that register can take it.
// Throughput: one byte per cycle, set by the single decode/accumulate stage;
// a result waiting in the output register stalls only a following last byte.
// Reset (rst, synchronous, active high) empties both registers and clears all
// decode, escape and width state; it is also cleared after every result.
// utf8_display_width_top: byte register, decode and saturating width sum,
// result register. Depends on udw_pkg.
`default_nettype none

module utf8_display_width_top #(
  parameter int unsigned WIDTH_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        last,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [19:0]      total_width,
  output logic             saturated
);
  import udw_pkg::*;

  localparam int unsigned SUM_W = WIDTH_BITS + 2;
  localparam logic [WIDTH_BITS-1:0] CNT_MAX = '1;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       advance;

  // Decode state
  logic [1:0]            cont_left, cont_left_next;
  logic [20:0]           partial, partial_next;
  logic                  pair_seq, pair_seq_next;
  esc_phase_t            phase, phase_next;
  logic [WIDTH_BITS-1:0] held, held_next;
  logic                  joined, joined_next;
  logic [WIDTH_BITS-1:0] total, total_next;
  logic                  ovf, ovf_next;

  // Per-byte working signals
  logic                  taken;
  logic                  fail;
  logic                  joined_mid;
  logic [WIDTH_BITS-1:0] held_inc;
  logic [1:0]            rest;
  logic [20:0]           cont_bits;
  logic                  fin;
  logic [20:0]           fin_cp;
  logic                  fin_len1;
  logic                  fin_len2;
  logic [1:0]            cols;
  logic [WIDTH_BITS-1:0] add_held;
  logic [SUM_W-1:0]      sum;

  // A non-last byte never needs the result register
  assign advance    = !s1_last || !result_valid || !result_stall;
  assign byte_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= text_byte;
      s1_last <= last;
    end
  end

  assign held_inc = (held == CNT_MAX) ? held : held + WIDTH_BITS'(1);

  // Escape tracking, UTF-8 decode and width accumulation for one byte
  always_comb begin
    taken          = 1'b0;
    fail           = 1'b0;
    phase_next     = phase;
    held_next      = held;
    cont_left_next = cont_left;
    partial_next   = partial;
    pair_seq_next  = pair_seq;
    rest           = 2'd0;
    cont_bits      = '0;
    fin            = 1'b0;
    fin_cp         = '0;
    fin_len1       = 1'b0;
    fin_len2       = 1'b0;
    cols           = 2'd0;

    // CSI continuation
    case (phase)
      PH_ESC: begin
        if (s1_byte == BYTE_BRACKET) begin
          taken      = 1'b1;
          held_next  = held_inc;
          phase_next = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (s1_byte inside {[8'h30:8'h3F]}) begin
          taken     = 1'b1;
          held_next = held_inc;
        end else if (s1_byte inside {[8'h20:8'h2F]}) begin
          taken      = 1'b1;
          held_next  = held_inc;
          phase_next = PH_INTER;
        end else if (s1_byte inside {[8'h40:8'h7E]}) begin
          taken      = 1'b1;
          held_next  = '0;
          phase_next = PH_IDLE;
        end
      end
      PH_INTER: begin
        if (s1_byte inside {[8'h20:8'h2F]}) begin
          taken     = 1'b1;
          held_next = held_inc;
        end else if (s1_byte inside {[8'h40:8'h7E]}) begin
          taken      = 1'b1;
          held_next  = '0;
          phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase

    // Failed CSI: held bytes count one each, ESC counts zero
    if (phase != PH_IDLE && !taken) begin
      fail       = 1'b1;
      phase_next = PH_IDLE;
      held_next  = '0;
      joined_mid = 1'b0;
    end else begin
      joined_mid = joined;
    end
    joined_next = joined_mid;

    // UTF-8 decode
    if (!taken) begin
      if (cont_left != 2'd0) begin
        rest = cont_left - 2'd1;
        case (rest)
          2'd0:    cont_bits = {15'd0, s1_byte[5:0]};
          2'd1:    cont_bits = {9'd0, s1_byte[5:0], 6'd0};
          default: cont_bits = {3'd0, s1_byte[5:0], 12'd0};
        endcase
        partial_next   = partial | cont_bits;
        cont_left_next = rest;
        if (rest == 2'd0) begin
          fin      = 1'b1;
          fin_cp   = partial_next;
          fin_len2 = pair_seq;
        end
      end else begin
        pair_seq_next = 1'b0;
        if (s1_byte[7:5] == 3'b110) begin
          cont_left_next = 2'd1;
          pair_seq_next  = 1'b1;
          partial_next   = {10'd0, s1_byte[4:0], 6'd0};
        end else if (s1_byte[7:4] == 4'b1110) begin
          cont_left_next = 2'd2;
          partial_next   = {5'd0, s1_byte[3:0], 12'd0};
        end else if (s1_byte[7:3] == 5'b11110) begin
          cont_left_next = 2'd3;
          partial_next   = {s1_byte[2:0], 18'd0};
        end else begin
          fin      = 1'b1;
          fin_cp   = {13'd0, s1_byte};
          fin_len1 = 1'b1;
        end
      end
    end

    // Finished codepoint: escape start, joiner handling or column count
    if (fin) begin
      if (fin_cp == CP_ESC && fin_len1) begin
        phase_next = PH_ESC;
        held_next  = '0;
      end else if (fin_cp == CP_ESC && fin_len2 && s1_byte == BYTE_BRACKET) begin
        phase_next = PH_PARAM;
        held_next  = '0;
      end else begin
        if (joined_mid) begin
          joined_next = 1'b0;
        end else begin
          cols = col_width(fin_cp);
        end
        if (fin_cp == CP_ZWJ) begin
          joined_next = 1'b1;
        end
      end
    end

    // String end inside a CSI fails it as well
    if (fail) begin
      add_held = held;
    end else if (s1_last && phase_next != PH_IDLE) begin
      add_held = held_next;
    end else begin
      add_held = '0;
    end

    // Saturating sum; the flag follows the count reaching its maximum
    sum = {2'b00, total} + {2'b00, add_held} + SUM_W'(cols);
    if (sum > {2'b00, CNT_MAX}) begin
      total_next = CNT_MAX;
    end else begin
      total_next = sum[WIDTH_BITS-1:0];
    end
    ovf_next = ovf || (total_next == CNT_MAX);
  end

  // State update; everything clears after a string's result
  always_ff @(posedge clk) begin
    if (rst || (s1_valid && advance && s1_last)) begin
      cont_left <= 2'd0;
      partial   <= '0;
      pair_seq  <= 1'b0;
      phase     <= PH_IDLE;
      held      <= '0;
      joined    <= 1'b0;
      total     <= '0;
      ovf       <= 1'b0;
    end else if (s1_valid && advance) begin
      cont_left <= cont_left_next;
      partial   <= partial_next;
      pair_seq  <= pair_seq_next;
      phase     <= phase_next;
      held      <= held_next;
      joined    <= joined_next;
      total     <= total_next;
      ovf       <= ovf_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_valid && advance && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance && s1_last) begin
      total_width <= OUT_W'(total_next);
      saturated   <= ovf_next;
    end
  end

endmodule

`default_nettype wire

### hdl/udw_checker.sv
// udw_checker: port-level checks for utf8_display_width_top, bound to it below.
// Depends only on the top level's ports.
`default_nettype none

module udw_checker #(
  parameter int unsigned WIDTH_BITS = 20
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        byte_valid,
  input wire logic        byte_stall,
  input wire logic [7:0]  text_byte,
  input wire logic        last,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [19:0] total_width,
  input wire logic        saturated
);

  localparam logic [WIDTH_BITS-1:0] CNT_MAX = '1;
  localparam logic [19:0] SHOWN_MAX = 20'(CNT_MAX);
  localparam bit FULL_VIEW = (WIDTH_BITS <= 20);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(total_width)
      && $stable(saturated))
    else $error("result changed while stalled");

  // When the whole count is visible, the flag means the count is at its maximum
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated && FULL_VIEW |-> total_width == SHOWN_MAX)
    else $error("saturated flag without a full count");

  a_max_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !saturated && FULL_VIEW |-> total_width != SHOWN_MAX)
    else $error("full count without saturated flag");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind utf8_display_width_top udw_checker #(.WIDTH_BITS(WIDTH_BITS)) u_udw_checker (.*);

`default_nettype wire
